@@ rtl/core/jpp_pkg.sv @@
// jpp_pkg: shared constants and types for the json pretty printer
// character codes and the per-item step plan passed from decoder to sequencer
// no dependencies
`timescale 1ns / 1ps

package jpp_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // bit positions of the output steps, in emission order
  localparam int STP_NL1   = 0;
  localparam int STP_IND1  = 1;
  localparam int STP_CHAR  = 2;
  localparam int STP_NL2   = 3;
  localparam int STP_IND2  = 4;
  localparam int STP_SPACE = 5;
  localparam int STP_NUL   = 6;
  localparam int NUM_STEPS = 7;

  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic                 err;
  } plan_t;

endpackage

@@ rtl/core/jpp_decode.sv @@
// jpp_decode: classifies one input byte against the parse state
// produces the step plan, indent count and next depth/string/escape state
// depends on jpp_pkg
`timescale 1ns / 1ps

module jpp_decode import jpp_pkg::*; #(
  parameter int MAX_DEPTH = 15,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [DW-1:0] depth_i,
  input  logic        in_str_i,
  input  logic        esc_i,
  output plan_t       plan_o,
  output logic [DW-1:0] depth_o,
  output logic        in_str_o,
  output logic        esc_o,
  output logic [DW:0] ind_cnt_o
);

  logic [DW-1:0] depth_ind;
  logic          str_n;
  logic          esc_n;
  logic          fin;
  logic          has_ind;

  assign fin     = in_last || (in_byte == CH_NUL);
  assign has_ind = (depth_ind != '0);

  always_comb begin
    plan_o    = '0;
    depth_ind = depth_i;
    str_n     = in_str_i;
    esc_n     = esc_i;
    if (in_byte == CH_NUL) begin
      plan_o.steps = '0;
    end else if (in_str_i) begin
      plan_o.steps[STP_CHAR] = 1'b1;
      if (esc_i) begin
        esc_n = 1'b0;
      end else if (in_byte == CH_BSLASH) begin
        esc_n = 1'b1;
      end else if (in_byte == CH_QUOTE) begin
        str_n = 1'b0;
      end
    end else begin
      case (in_byte) inside
        CH_LBRACE, CH_LBRACK: begin
          if (depth_i < DW'(MAX_DEPTH)) begin
            depth_ind = depth_i + 1'b1;
          end else begin
            depth_ind  = DW'(MAX_DEPTH);
            plan_o.err = 1'b1;
          end
          plan_o.steps[STP_CHAR] = 1'b1;
          plan_o.steps[STP_NL2]  = 1'b1;
          plan_o.steps[STP_IND2] = (depth_ind != '0);
        end
        CH_RBRACE, CH_RBRACK: begin
          if (depth_i != '0) begin
            depth_ind = depth_i - 1'b1;
          end else begin
            plan_o.err = 1'b1;
          end
          plan_o.steps[STP_NL1]  = 1'b1;
          plan_o.steps[STP_IND1] = (depth_ind != '0);
          plan_o.steps[STP_CHAR] = 1'b1;
        end
        CH_COMMA: begin
          plan_o.steps[STP_CHAR] = 1'b1;
          plan_o.steps[STP_NL2]  = 1'b1;
          plan_o.steps[STP_IND2] = has_ind;
        end
        CH_COLON: begin
          plan_o.steps[STP_CHAR]  = 1'b1;
          plan_o.steps[STP_SPACE] = 1'b1;
        end
        CH_SP, CH_TAB, CH_LF, CH_CR: begin
          plan_o.steps = '0;
        end
        CH_QUOTE: begin
          str_n = 1'b1;
          plan_o.steps[STP_CHAR] = 1'b1;
        end
        default: begin
          plan_o.steps[STP_CHAR] = 1'b1;
        end
      endcase
    end
    plan_o.steps[STP_NUL] = fin;
  end

  assign ind_cnt_o = {depth_ind, 1'b0};
  assign depth_o   = fin ? '0 : depth_ind;
  assign in_str_o  = fin ? 1'b0 : str_n;
  assign esc_o     = fin ? 1'b0 : esc_n;

endmodule

@@ rtl/core/json_pretty_printer.sv @@
// json_pretty_printer: top level, byte-stream JSON reformatter
// sequencer with a shared indent down-counter and a registered output stage
// depends on jpp_pkg and jpp_decode
//
// usage: compact JSON enters one byte per item on the in_ channel (in_tdata
// byte, in_tlast marks the last byte of a document). formatted bytes leave
// on the out_ channel, one per item; out_tlast marks the last result of an
// input byte, out_tuser carries stream_end (terminating NUL) and the depth
// error flag of that input byte.
// an input byte is registered into the sequencer, then its results are sent
// one per cycle while the output register is free; no new byte is taken
// until an item's last result is sent, set by the single output byte path
// and the indent counter that emits two spaces per nesting level. a dropped
// whitespace byte not marked last gives no result. results leave through the output register.
// when the receiver holds out_tready low, the output register holds its
// item and the sequencer waits; one finished result may wait while the next
// byte is accepted. reset clears depth, string and escape state and empties
// the output register.
`timescale 1ns / 1ps

module json_pretty_printer import jpp_pkg::*; #(
  parameter int MAX_DEPTH = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] stream_end, [1] depth_error
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NL1   = 3'(STP_NL1 + 1);
  localparam logic [2:0] ST_IND1  = 3'(STP_IND1 + 1);
  localparam logic [2:0] ST_CHAR  = 3'(STP_CHAR + 1);
  localparam logic [2:0] ST_NL2   = 3'(STP_NL2 + 1);
  localparam logic [2:0] ST_IND2  = 3'(STP_IND2 + 1);
  localparam logic [2:0] ST_SPACE = 3'(STP_SPACE + 1);
  localparam logic [2:0] ST_NUL   = 3'(STP_NUL + 1);

  logic [2:0]           state_r, state_nxt;
  logic [NUM_STEPS-1:0] steps_r, steps_nxt;
  logic                 err_r, err_nxt;
  logic [7:0]           chr_r, chr_nxt;
  logic [DW:0]          cnt_r, cnt_nxt;
  logic [DW-1:0]        depth_r, depth_nxt;
  logic                 in_str_r, in_str_nxt;
  logic                 esc_r, esc_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_err_r, out_err_nxt;

  plan_t         plan;
  logic [DW-1:0] dec_depth;
  logic          dec_str;
  logic          dec_esc;
  logic [DW:0]   dec_cnt;
  logic          accept;
  logic          slot_free;
  logic          is_ind;
  logic          more_ind;
  logic [2:0]    after;

  function automatic logic [2:0] next_step(input logic [NUM_STEPS-1:0] st,
                                           input logic [2:0] from);
    logic [2:0] res;
    res = ST_IDLE;
    for (int j = NUM_STEPS; j >= 1; j--) begin
      if ((3'(j) > from) && st[j-1]) begin
        res = 3'(j);
      end
    end
    return res;
  endfunction

  jpp_decode #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_decode (
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .depth_i  (depth_r),
    .in_str_i (in_str_r),
    .esc_i    (esc_r),
    .plan_o   (plan),
    .depth_o  (dec_depth),
    .in_str_o (dec_str),
    .esc_o    (dec_esc),
    .ind_cnt_o(dec_cnt)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_vld_r || out_tready;
  assign is_ind    = (state_r == ST_IND1) || (state_r == ST_IND2);
  assign more_ind  = is_ind && (cnt_r > (DW+1)'(1));
  assign after     = next_step(steps_r, state_r);

  always_comb begin
    state_nxt    = state_r;
    steps_nxt    = steps_r;
    err_nxt      = err_r;
    chr_nxt      = chr_r;
    cnt_nxt      = cnt_r;
    depth_nxt    = depth_r;
    in_str_nxt   = in_str_r;
    esc_nxt      = esc_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_end_nxt  = out_end_r;
    out_err_nxt  = out_err_r;
    if (accept) begin
      state_nxt  = next_step(plan.steps, ST_IDLE);
      steps_nxt  = plan.steps;
      err_nxt    = plan.err;
      chr_nxt    = in_tdata;
      cnt_nxt    = dec_cnt;
      depth_nxt  = dec_depth;
      in_str_nxt = dec_str;
      esc_nxt    = dec_esc;
    end else if ((state_r != ST_IDLE) && slot_free) begin
      out_vld_nxt  = 1'b1;
      out_err_nxt  = err_r;
      out_end_nxt  = (state_r == ST_NUL);
      out_last_nxt = !more_ind && (after == ST_IDLE);
      case (state_r)
        ST_NL1, ST_NL2:             out_byte_nxt = CH_LF;
        ST_IND1, ST_IND2, ST_SPACE: out_byte_nxt = CH_SP;
        ST_CHAR:                    out_byte_nxt = chr_r;
        default:                    out_byte_nxt = CH_NUL;
      endcase
      if (more_ind) begin
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        state_nxt = after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      depth_r   <= '0;
      in_str_r  <= 1'b0;
      esc_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      depth_r   <= depth_nxt;
      in_str_r  <= in_str_nxt;
      esc_r     <= esc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r    <= steps_nxt;
    err_r      <= err_nxt;
    chr_r      <= chr_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_end_r};

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("nesting depth above limit");

  a_ind_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IND1) || (state_r == ST_IND2)) |-> (cnt_r != '0))
    else $error("indent step entered with zero count");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_end_r) |-> (out_last_r && (out_byte_r == CH_NUL)))
    else $error("stream end item is not a final NUL");

  a_doc_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> ((depth_r == '0) && !in_str_r && !esc_r))
    else $error("parse state not cleared after final byte");

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for json_pretty_printer
// a scoreboard class predicts every formatted byte from accepted input bytes and
// checks the out_ stream. depends on jpp_pkg and json_pretty_printer
`timescale 1ns / 1ps

module tb_top import jpp_pkg::*; ();

  localparam int DEPTH_LIMIT = 15;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 17;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } raw_item_t;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
    logic       depth_err;
  } fmt_item_t;

  class format_scoreboard;
    fmt_item_t  pending_bytes[$];
    logic [4:0] nest;
    logic       in_str;
    logic       esc;
    int         errors;

    function new();
      nest = '0;
      in_str = 1'b0;
      esc = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // works out the formatted bytes that one accepted input byte causes
    function void predict_layout(logic [7:0] c, logic last_in);
      logic [7:0] seq[$];
      logic       err;
      logic       fin;
      fmt_item_t  e;
      err = 1'b0;
      fin = last_in;
      if (c == CH_NUL) begin
        fin = 1'b1;
      end else if (in_str) begin
        if (esc) esc = 1'b0;
        else if (c == CH_BSLASH) esc = 1'b1;
        else if (c == CH_QUOTE) in_str = 1'b0;
        seq.push_back(c);
      end else begin
        case (c)
          CH_LBRACE, CH_LBRACK: begin
            seq.push_back(c);
            if (nest < DEPTH_LIMIT) nest = nest + 1'b1;
            else err = 1'b1;
            seq.push_back(CH_LF);
            repeat (2 * nest) seq.push_back(CH_SP);
          end
          CH_RBRACE, CH_RBRACK: begin
            if (nest > 0) nest = nest - 1'b1;
            else err = 1'b1;
            seq.push_back(CH_LF);
            repeat (2 * nest) seq.push_back(CH_SP);
            seq.push_back(c);
          end
          CH_COMMA: begin
            seq.push_back(c);
            seq.push_back(CH_LF);
            repeat (2 * nest) seq.push_back(CH_SP);
          end
          CH_COLON: begin
            seq.push_back(c);
            seq.push_back(CH_SP);
          end
          CH_SP, CH_TAB, CH_LF, CH_CR: ;
          CH_QUOTE: begin
            in_str = 1'b1;
            seq.push_back(c);
          end
          default: seq.push_back(c);
        endcase
      end
      if (fin) begin
        seq.push_back(CH_NUL);
        nest = '0;
        in_str = 1'b0;
        esc = 1'b0;
      end
      foreach (seq[i]) begin
        e.data = seq[i];
        e.run_last = (i == seq.size() - 1);
        e.stream_end = fin && (i == seq.size() - 1);
        e.depth_err = err;
        pending_bytes.push_back(e);
      end
    endfunction

    task check_result(logic [7:0] data, logic tlast, logic [1:0] tuser);
      fmt_item_t e;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item data=%02h", data));
        return;
      end
      e = pending_bytes.pop_front();
      if (data !== e.data)
        report_mismatch($sformatf("out_byte %02h, want %02h", data, e.data));
      if (tlast !== e.run_last)
        report_mismatch($sformatf("run_last %b, want %b (byte %02h)", tlast, e.run_last, e.data));
      if (tuser[0] !== e.stream_end)
        report_mismatch($sformatf("stream_end %b, want %b", tuser[0], e.stream_end));
      if (tuser[1] !== e.depth_err)
        report_mismatch($sformatf("depth_error %b, want %b (byte %02h)",
                                  tuser[1], e.depth_err, e.data));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;
  logic [1:0] out_tuser;  // [0] stream_end, [1] depth_error

  format_scoreboard sb;
  raw_item_t        text_q[$];
  int               accepted_in;
  int               counted;
  int               cycles;

  json_pretty_printer #(.MAX_DEPTH(DEPTH_LIMIT)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // no idling in a window of items
  function automatic bit calm_window();
    return accepted_in >= 100 && accepted_in < 140;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic last, bit counts);
    raw_item_t t;
    t.data = b;
    t.last = last;
    text_q.push_back(t);
    if (counts) counted++;
  endfunction

  function automatic void push_text(string s, logic last_on_end);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], last_on_end && (i == s.len() - 1), 1'b1);
  endfunction

  function automatic void push_string();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 5);
    push_byte(CH_QUOTE, 1'b0, 1'b1);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        push_byte(CH_BSLASH, 1'b0, 1'b1);
        push_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == CH_QUOTE || b == CH_BSLASH) b = CH_SP;
        push_byte(b, 1'b0, 1'b1);
      end
    end
    push_byte(CH_QUOTE, 1'b0, 1'b1);
  endfunction

  function automatic void push_word();
    string alpha;
    alpha = "0123456789-.eEtruefalsn";
    repeat ($urandom_range(1, 4)) push_byte(alpha[$urandom_range(0, alpha.len() - 1)], 1'b0, 1'b1);
  endfunction

  // mostly well-formed documents with random content, some noise and broken ones
  function automatic void gen_doc(bit deep);
    int d;
    int tok;
    d = 0;
    if (deep) begin
      repeat (DEPTH_LIMIT + 2) begin
        push_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK, 1'b0, 1'b1);
        d++;
      end
    end
    repeat ($urandom_range(4, 14)) begin
      tok = $urandom_range(0, 99);
      if (tok < 15) begin
        push_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK, 1'b0, 1'b1);
        d++;
      end else if (tok < 28 && d > 0) begin
        push_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK, 1'b0, 1'b1);
        d--;
      end else if (tok < 40) begin
        push_byte(CH_COMMA, 1'b0, 1'b1);
      end else if (tok < 48) begin
        push_byte(CH_COLON, 1'b0, 1'b1);
      end else if (tok < 65) begin
        push_string();
      end else if (tok < 80) begin
        push_word();
      end else if (tok < 88) begin
        case ($urandom_range(0, 3))
          0: push_byte(CH_SP, 1'b0, 1'b0);
          1: push_byte(CH_TAB, 1'b0, 1'b0);
          2: push_byte(CH_LF, 1'b0, 1'b0);
          default: push_byte(CH_CR, 1'b0, 1'b0);
        endcase
      end else if (tok < 96) begin
        push_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
      end else if (tok < 98) begin
        push_byte(CH_NUL, 1'b0, 1'b1);
        d = 0;
      end else begin
        push_byte(CH_RBRACK, 1'b0, 1'b1);
        if (d > 0) d--;
      end
    end
    while (d > 0) begin
      push_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK, 1'b0, 1'b1);
      d--;
    end
    if ($urandom_range(0, 3) == 0) push_byte(CH_RBRACE, 1'b0, 1'b1);
    text_q[$].last = 1'b1;
  endfunction

  task automatic drive_text();
    raw_item_t t;
    while (text_q.size() > 0) begin
      t = text_q.pop_front();
      @(negedge clk);
      while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= t.data;
      in_tlast <= t.last;
      do @(posedge clk); while (!in_tready);
      sb.predict_layout(t.data, t.last);
      accepted_in++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drive_ready();
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && accepted_in >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (calm_window()) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  endtask

  initial begin
    int ndoc;
    sb = new();
    cycles = 0;
    accepted_in = 0;
    counted = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;

    // escapes, space inside a string, dropped tab, every bracket and separator
    push_text("{\"k\\\" \":[7,\t0]}", 1'b1);
    push_byte(CH_RBRACK, 1'b1, 1'b1);       // underflow on final byte
    push_byte(CH_QUOTE, 1'b0, 1'b1);
    push_byte("x", 1'b0, 1'b1);
    push_byte(CH_NUL, 1'b0, 1'b1);          // nul inside a string
    push_byte(CH_SP, 1'b1, 1'b1);           // dropped byte marked last
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h80, 1'b0, 1'b1);
    push_byte(CH_LF, 1'b0, 1'b0);
    push_byte(CH_CR, 1'b0, 1'b0);
    push_byte(CH_NUL, 1'b1, 1'b1);
    ndoc = 0;
    while (counted < RANDOM_ITEMS) begin
      gen_doc(ndoc == 1 || ndoc == 6);
      ndoc++;
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    fork
      drive_ready();
    join_none
    drive_text();
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
